### sv/assert_macros.svh
// Assertion macros for the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check sampled on clk, switched off while arst_n is low.
`define AST_CLKD(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check sampled on clk that also holds while reset is applied.
`define AST_CLKD_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/x86d_pkg.sv
// Types, opcode constants and decode functions for the x86 subset decoder.
`default_nettype none
package x86d_pkg;

	typedef enum logic [3:0] {
		K_NONE      = 4'd0,
		K_PUSH_IMM8 = 4'd1,
		K_PUSH_IMM  = 4'd2,
		K_INC       = 4'd3,
		K_DEC       = 4'd4,
		K_PUSH      = 4'd5,
		K_POP       = 4'd6,
		K_MOV_IMM   = 4'd7,
		K_ADD_I8    = 4'd8,
		K_ADC_I8    = 4'd9,
		K_AND_I8    = 4'd10,
		K_ADD_IMM   = 4'd11,
		K_ADD_ACC   = 4'd12,
		K_TEST      = 4'd13,
		K_CALL      = 4'd14,
		K_JMP       = 4'd15
	} kind_t;

	localparam logic [7:0] OP_PFX_OPSZ = 8'h66;
	localparam logic [7:0] OP_PFX_ADSZ = 8'h67;
	localparam logic [7:0] OP_PUSH_I8  = 8'h6a;
	localparam logic [7:0] OP_PUSH_I   = 8'h68;
	localparam logic [7:0] OP_GRP_I8   = 8'h83;
	localparam logic [7:0] OP_GRP_I    = 8'h81;
	localparam logic [7:0] OP_ADD_ACC  = 8'h05;
	localparam logic [7:0] OP_TEST     = 8'h85;
	localparam logic [7:0] OP_CALL     = 8'he8;
	localparam logic [7:0] OP_JMP      = 8'he9;
	// register-in-opcode forms: base with low three bits zero
	localparam logic [7:0] OP_INC      = 8'h40;
	localparam logic [7:0] OP_DEC      = 8'h48;
	localparam logic [7:0] OP_PUSH     = 8'h50;
	localparam logic [7:0] OP_POP      = 8'h58;
	localparam logic [7:0] OP_MOV_I    = 8'hb8;
	// ModRM, register-direct with reg field /0, /2, /4
	localparam logic [7:0] MRM_ADD     = 8'hc0;
	localparam logic [7:0] MRM_ADC     = 8'hd0;
	localparam logic [7:0] MRM_AND     = 8'he0;

	typedef struct packed {
		kind_t       kind;
		logic        o16;
		logic [2:0]  reg_a;
		logic [2:0]  reg_b;
		logic [31:0] imm;
		logic [2:0]  length;
	} res_t;

	typedef struct packed {
		logic       known;
		logic [2:0] count;
	} trail_t;

	function automatic logic is_grp(input logic [7:0] op, input logic [7:0] base);
		return op[7:3] == base[7:3];
	endfunction

	// trailing bytes (ModRM + immediate) after an opcode
	function automatic trail_t trailing(input logic [7:0] op, input logic p);
		trail_t t;
		t.known = 1'b1;
		t.count = 3'd0;
		priority if (is_grp(op, OP_INC) || is_grp(op, OP_DEC) ||
			is_grp(op, OP_PUSH) || is_grp(op, OP_POP))
			t.count = 3'd0;
		else if (op == OP_PUSH_I8 || op == OP_TEST)
			t.count = 3'd1;
		else if (op == OP_GRP_I8)
			t.count = 3'd2;
		else if (op == OP_GRP_I)
			t.count = p ? 3'd3 : 3'd5;
		else if (op == OP_PUSH_I || op == OP_ADD_ACC || op == OP_CALL ||
			op == OP_JMP || is_grp(op, OP_MOV_I))
			t.count = p ? 3'd2 : 3'd4;
		else
			t.known = 1'b0;
		return t;
	endfunction

	function automatic logic has_modrm(input logic [7:0] op);
		return op == OP_GRP_I8 || op == OP_GRP_I || op == OP_TEST;
	endfunction

	// result for a completed instruction
	function automatic res_t finish(input logic [7:0] op, input logic [7:0] m,
		input logic p, input logic [31:0] imm, input logic [2:0] len);
		res_t        r;
		logic [31:0] mask;
		logic [31:0] tgt;
		mask = p ? 32'h0000_ffff : 32'hffff_ffff;
		tgt  = (imm + {29'd0, len}) & mask;
		r = '0;
		r.length = len;
		r.o16 = p;
		priority if (is_grp(op, OP_INC)) begin
			r.kind = K_INC; r.reg_a = op[2:0];
		end else if (is_grp(op, OP_DEC)) begin
			r.kind = K_DEC; r.reg_a = op[2:0];
		end else if (is_grp(op, OP_PUSH)) begin
			r.kind = K_PUSH; r.reg_a = op[2:0];
		end else if (is_grp(op, OP_POP)) begin
			r.kind = K_POP; r.reg_a = op[2:0];
		end else if (op == OP_PUSH_I8) begin
			r.kind = K_PUSH_IMM8; r.imm = {24'd0, imm[7:0]};
		end else if (op == OP_PUSH_I) begin
			r.kind = K_PUSH_IMM; r.imm = imm & mask;
		end else if (is_grp(op, OP_MOV_I)) begin
			r.kind = K_MOV_IMM; r.reg_a = op[2:0]; r.imm = imm & mask;
		end else if (op == OP_ADD_ACC) begin
			r.kind = K_ADD_ACC; r.imm = imm & mask;
		end else if (op == OP_GRP_I8) begin
			r.reg_a = m[2:0];
			r.imm = {24'd0, imm[7:0]};
			priority if (is_grp(m, MRM_ADD)) r.kind = K_ADD_I8;
			else if (is_grp(m, MRM_ADC)) r.kind = K_ADC_I8;
			else if (is_grp(m, MRM_AND)) r.kind = K_AND_I8;
			else r.kind = K_NONE;
		end else if (op == OP_GRP_I) begin
			r.reg_a = m[2:0];
			r.imm = imm & mask;
			r.kind = is_grp(m, MRM_ADD) ? K_ADD_IMM : K_NONE;
		end else if (op == OP_TEST) begin
			r.reg_a = m[2:0];
			r.reg_b = m[5:3];
			r.kind = (m[7:6] == MRM_ADD[7:6]) ? K_TEST : K_NONE;
		end else if (op == OP_CALL) begin
			r.kind = K_CALL; r.imm = tgt;
		end else if (op == OP_JMP) begin
			r.kind = K_JMP; r.imm = tgt;
		end else begin
			r.kind = K_NONE;
		end
		if (r.kind == K_NONE) begin
			r = '0;
			r.length = len;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### sv/x86d_decode.sv
// Per-byte decode step: item state registers and the result logic for one byte.
`default_nettype none
module x86d_decode (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            fire,
	input  wire logic [7:0]      code_byte,
	input  wire logic            end_of_code,
	output x86d_pkg::res_t       res,
	output logic                 res_valid
);
	import x86d_pkg::*;

	logic        op_pfx_q, adr_pfx_q;
	logic [7:0]  opcode_q, modrm_q;
	logic [2:0]  taken_q, need_q;
	logic [31:0] imm_q;

	logic        op_pfx_d, adr_pfx_d;
	logic [7:0]  opcode_d, modrm_d;
	logic [2:0]  taken_d, need_d;
	logic [31:0] imm_d;

	logic [2:0]  len, pre, tidx, need_w, lane3;
	logic [7:0]  modrm_w;
	logic [31:0] imm_w;
	logic        hm, dup;
	trail_t      tr;

	always_comb begin
		op_pfx_d  = op_pfx_q;
		adr_pfx_d = adr_pfx_q;
		opcode_d  = opcode_q;
		modrm_d   = modrm_q;
		taken_d   = taken_q;
		need_d    = need_q;
		imm_d     = imm_q;
		res       = '0;
		res_valid = 1'b0;
		len       = taken_q + 3'd1;
		tr        = trailing(code_byte, op_pfx_q);
		pre       = {2'b00, op_pfx_q} + {2'b00, adr_pfx_q};
		tidx      = taken_q - pre - 3'd1;
		hm        = has_modrm(opcode_q);
		lane3     = tidx - {2'b00, hm};
		dup       = (code_byte == OP_PFX_OPSZ) ? op_pfx_q : adr_pfx_q;
		modrm_w   = modrm_q;
		imm_w     = imm_q;
		need_w    = need_q - 3'd1;

		if (need_q == 3'd0) begin
			if (code_byte == OP_PFX_OPSZ || code_byte == OP_PFX_ADSZ) begin
				if (dup || end_of_code) begin
					res_valid = 1'b1;
					res.length = len;
				end else begin
					if (code_byte == OP_PFX_OPSZ)
						op_pfx_d = 1'b1;
					else
						adr_pfx_d = 1'b1;
					taken_d = len;
				end
			end else if (!tr.known || (tr.count != 3'd0 && end_of_code)) begin
				res_valid = 1'b1;
				res.length = len;
			end else if (tr.count == 3'd0) begin
				res_valid = 1'b1;
				res = finish(code_byte, 8'h00, op_pfx_q, 32'd0, len);
			end else begin
				opcode_d = code_byte;
				modrm_d  = 8'h00;
				imm_d    = 32'd0;
				need_d   = tr.count;
				taken_d  = len;
			end
		end else begin
			if (hm && tidx == 3'd0)
				modrm_w = code_byte;
			else
				imm_w = imm_q | ({24'd0, code_byte} << {lane3[1:0], 3'b000});
			if (need_w == 3'd0) begin
				res_valid = 1'b1;
				res = finish(opcode_q, modrm_w, op_pfx_q, imm_w, len);
			end else if (end_of_code) begin
				res_valid = 1'b1;
				res.length = len;
			end else begin
				modrm_d = modrm_w;
				imm_d   = imm_w;
				need_d  = need_w;
				taken_d = len;
			end
		end

		// any result closes the item
		if (res_valid) begin
			op_pfx_d  = 1'b0;
			adr_pfx_d = 1'b0;
			opcode_d  = 8'h00;
			modrm_d   = 8'h00;
			taken_d   = 3'd0;
			need_d    = 3'd0;
			imm_d     = 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_pfx_q  <= 1'b0;
			adr_pfx_q <= 1'b0;
			opcode_q  <= 8'h00;
			modrm_q   <= 8'h00;
			taken_q   <= 3'd0;
			need_q    <= 3'd0;
			imm_q     <= 32'd0;
		end else if (fire) begin
			op_pfx_q  <= op_pfx_d;
			adr_pfx_q <= adr_pfx_d;
			opcode_q  <= opcode_d;
			modrm_q   <= modrm_d;
			taken_q   <= taken_d;
			need_q    <= need_d;
			imm_q     <= imm_d;
		end
	end

endmodule
`default_nettype wire

### sv/x86_subset_instruction_decoder.sv
// Top level of the x86 subset decoder: input register, decode step, result register.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in      | sink      | in_valid / in_ready   | code_byte, end_of_code
//  out     | source    | out_valid / out_ready | kind, operand_16, reg_a, reg_b,
//          |           |                       | immediate, length
//
// One code byte per clock while the result is not stalled. A byte waits in the input register, is
// decoded against the item state once the result register has room, and any result appears in
// the result register the cycle after; one byte per cycle sustained while the result is not stalled.
// Reset (arst_n low) empties both registers and clears the item state.
// A stalled result blocks only the byte waiting in the input register; in_ready drops
// only when that register is full and the result register cannot be emptied.
`default_nettype none
`include "assert_macros.svh"
module x86_subset_instruction_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  code_byte,
	input  wire logic        end_of_code,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       kind,
	output logic             operand_16,
	output logic [2:0]       reg_a,
	output logic [2:0]       reg_b,
	output logic [31:0]      immediate,
	output logic [2:0]       length
);
	import x86d_pkg::*;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eoc_s1;

	// result register
	logic       out_valid_q;
	res_t       res_q;

	res_t       res;
	logic       res_valid;
	logic       adv;

	// the held byte is decoded when the result register has room for its result
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= code_byte;
			eoc_s1  <= end_of_code;
		end
	end

	x86d_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (adv),
		.code_byte  (byte_s1),
		.end_of_code(eoc_s1),
		.res        (res),
		.res_valid  (res_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = res_q.kind;
	assign operand_16 = res_q.o16;
	assign reg_a      = res_q.reg_a;
	assign reg_b      = res_q.reg_b;
	assign immediate  = res_q.imm;
	assign length     = res_q.length;

	// a none result never carries operand fields
	`AST_CLKD(a_none_clean, (out_valid && kind == K_NONE) |-> (!operand_16 && reg_a == 3'd0 && reg_b == 3'd0 && immediate == 32'd0), "none result with non-zero fields")
	// every transfer consumes at least one byte
	`AST_CLKD(a_len_nonzero, out_valid |-> (length != 3'd0), "result with zero length")
	// input is held off only by a stalled result with a byte waiting
	`AST_CLKD(a_ready_cause, !in_ready |-> (valid_s1 && out_valid_q && !out_ready), "in_ready low without a stall")
	// both registers are empty on the edge after reset is seen
	`AST_CLKD_ALWAYS(a_reset_quiet, !arst_n |=> (!out_valid && !valid_s1), "activity during reset")

endmodule
`default_nettype wire
